// ===== sv/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and constants of the polygon point reflector
// Field widths, fixed-point format, operation codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ppr_pkg;

	localparam int MAX_PANELS_DEF  = 256;
	localparam int COORD_WIDTH_DEF = 32;

	// Fraction bits of the reflection coefficients (signed Q1.30).
	localparam int FRAC_BITS = 30;

	localparam int CFG_WIDTH       = 9;
	localparam int IDX_WIDTH       = 9;
	localparam int PANEL_OUT_WIDTH = 8;
	localparam int PANEL_COUNT_MIN = 3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CROSS,
		ST_DECIDE,
		ST_NEAR,
		ST_FETCH,
		ST_SQ,
		ST_PREP,
		ST_DIV_A,
		ST_DIV_B,
		ST_MUL_A,
		ST_MUL_B,
		ST_ROUND,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== sv/ppr_divider.sv =====
// ----------------------------------------------------------------------------
// ppr_divider: restoring ratio divider
// Computes round(num * 2^FRAC_BITS / den) for num <= den, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_divider #(
	parameter int NW = 63
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [NW-1:0]                num,
	input  wire logic [NW-1:0]                den,
	output logic                              done,
	output logic [ppr_pkg::FRAC_BITS:0]       quot
);
	import ppr_pkg::*;

	localparam int QW = FRAC_BITS + 2;
	localparam int KW = $clog2(FRAC_BITS + 1);

	logic [NW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NW:0]   rem_sh;
	logic          fits;
	logic [NW:0]   rem_sub;
	logic [QW-1:0] quo_p1;

	assign rem_sh  = {rem_q, 1'b0};
	assign fits    = rem_sh >= {1'b0, den};
	assign rem_sub = rem_sh - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == KW'(FRAC_BITS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (num >= den) begin
				quo_q <= QW'(1);
				rem_q <= '0;
			end else begin
				quo_q <= '0;
				rem_q <= num;
			end
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_sub[NW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[NW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	// The extra quotient bit rounds to nearest, ties away from zero.
	assign quo_p1 = quo_q + 1'b1;
	assign quot   = quo_p1[QW-1:1];
	assign done   = done_q;

endmodule

`default_nettype wire

// ===== sv/polygon_point_reflect.sv =====
// A vertex load gives no result; one request is worked at a time.
// A query outside the polygon gives its result after the crossing scan alone.
// An inside query runs two memory scans, two 31-step divisions and the rounding steps.
// The single read port of the vertex memory paces both scans, one vertex per cycle.
// Reset sets panel_count to 3; the vertex memory is not cleared and holds junk until loaded.
// ----------------------------------------------------------------------------
// polygon_point_reflect: point-in-polygon test with reflection
// Odd-parity crossing test, nearest panel midpoint search and reflection of
// an inside point across that panel's line, in signed Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_point_reflect #(
	parameter int MAX_PANELS  = ppr_pkg::MAX_PANELS_DEF,
	parameter int COORD_WIDTH = ppr_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  operation,
	input  wire logic [ppr_pkg::IDX_WIDTH-1:0]         vertex_index,
	input  wire logic signed [COORD_WIDTH-1:0]         x,
	input  wire logic signed [COORD_WIDTH-1:0]         z,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [COORD_WIDTH-1:0]              x_out,
	output logic signed [COORD_WIDTH-1:0]              z_out,
	output logic                                       was_inside,
	output logic [ppr_pkg::PANEL_OUT_WIDTH-1:0]        nearest_panel,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [ppr_pkg::CFG_WIDTH-1:0]         cfg_data
);
	import ppr_pkg::*;

	localparam int W     = COORD_WIDTH;
	localparam int DEPTH = MAX_PANELS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 2;
	localparam int PW    = 2 * W + 2;
	localparam int DW    = PW + 1;
	localparam int NW    = 2 * W - 1;
	localparam int AQ    = FRAC_BITS + 2;
	localparam int MW    = W + 1 + AQ;
	localparam int SW    = MW + 1;

	localparam logic signed [AQ-1:0] ONE_Q  = AQ'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0] RND    = SW'(1) << (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

	// Control
	state_t        state_q, state_d;
	logic [AW-1:0] n_q;
	logic [AW-1:0] n_cfg;
	logic [CW-1:0] cnt_q;
	logic          in_acc, query_acc, mem_we;
	logic          scan, rd_en, cnt_inc, div_start, load_out, scan_end;
	logic [AW-1:0] ra;
	logic          parity_q;
	logic          out_valid_q;

	// Memory and scan pipeline
	logic signed [W-1:0] mem_x [DEPTH];
	logic signed [W-1:0] mem_z [DEPTH];
	logic signed [W-1:0] rdx_s1, rdz_s1;
	logic                v_s1, v_s2, v_s3;
	logic [AW-1:0]       idx_s1, j_s2, j_s3;
	logic signed [W-1:0] prevx_q, prevz_q;
	logic signed [W-1:0] px_q, pz_q;
	logic [W:0]          op1a, op1b, op2a, op2b;
	logic                c_cond, c_ln, c_rn;
	logic [W:0]          op1a_s2, op1b_s2, op2a_s2, op2b_s2;
	logic                cond_s2, ln_s2, rn_s2, cond_s3, ln_s3, rn_s3;
	logic [PW-1:0]       prod1_s3, prod2_s3;
	logic                lt_cross, n1, n2;
	logic [DW-1:0]       dsum, bestd_q;
	logic [AW-1:0]       best_q;

	// Reflection
	logic signed [W-1:0]   x0_q, z0_q;
	logic signed [W:0]     dxf, dzf, uxf, uzf;
	logic [W-1:0]          adxf, adzf;
	logic                  big;
	logic [W-2:0]          adx_q, adz_q;
	logic                  dxn_q, dzn_q;
	logic signed [W:0]     ux_q, uz_q;
	logic [2*W-3:0]        dx2_q, dz2_q, dxdz_q;
	logic [NW-1:0]         len_q, amag_q, bmag_q;
	logic                  aneg_q, bneg_q, lenz_q;
	logic                  div_done;
	logic [FRAC_BITS:0]    div_quot;
	logic signed [AQ-1:0]  qs;
	logic signed [AQ-1:0]  a_q, b_q;
	logic signed [MW-1:0]  m1_q, m2_q, m3_q, m4_q;
	logic signed [SW-1:0]  sx_q, sz_q, fx, fz;
	logic signed [W-1:0]   rx, rz;

	logic signed [W-1:0]   x_out_q, z_out_q;
	logic                  inside_out_q;
	logic [PANEL_OUT_WIDTH-1:0] panel_out_q;

	// Configuration
	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data < CFG_WIDTH'(PANEL_COUNT_MIN)) begin
			n_cfg = AW'(PANEL_COUNT_MIN);
		end else if (int'(cfg_data) > MAX_PANELS) begin
			n_cfg = AW'(MAX_PANELS);
		end else begin
			n_cfg = AW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= AW'(PANEL_COUNT_MIN);
		end else if (cfg_valid) begin
			n_q <= n_cfg;
		end
	end

	// Handshake
	assign in_acc    = in_valid && !in_stall;
	assign query_acc = in_acc && (operation == OP_QUERY);
	assign mem_we    = in_acc && (operation == OP_LOAD) && (int'(vertex_index) <= MAX_PANELS);
	assign scan_end  = cnt_q == (CW'(n_q) + CW'(3));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (query_acc) state_d = ST_CROSS;
			ST_CROSS:  if (scan_end) state_d = ST_DECIDE;
			ST_DECIDE: state_d = parity_q ? ST_NEAR : ST_DONE;
			ST_NEAR:   if (scan_end) state_d = ST_FETCH;
			ST_FETCH:  if (cnt_q == CW'(2)) state_d = ST_SQ;
			ST_SQ:     state_d = ST_PREP;
			ST_PREP:   state_d = ST_DIV_A;
			ST_DIV_A:  if (div_done) state_d = ST_DIV_B;
			ST_DIV_B:  if (div_done) state_d = ST_MUL_A;
			ST_MUL_A:  state_d = ST_MUL_B;
			ST_MUL_B:  state_d = ST_ROUND;
			ST_ROUND:  state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		in_stall  = 1'b1;
		scan      = 1'b0;
		cnt_inc   = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		ra        = cnt_q[AW-1:0];
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_CROSS, ST_NEAR: begin
				scan    = 1'b1;
				cnt_inc = 1'b1;
			end
			ST_FETCH: begin
				cnt_inc = 1'b1;
				ra      = (cnt_q == '0) ? best_q : best_q + 1'b1;
			end
			ST_DIV_A, ST_DIV_B: begin
				div_start = cnt_q == '0;
				cnt_inc   = cnt_q == '0;
			end
			ST_DONE: load_out = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	assign rd_en = scan && (cnt_q <= CW'(n_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Vertex memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_x[AW'(vertex_index)] <= x;
			mem_z[AW'(vertex_index)] <= z;
		end
		rdx_s1 <= mem_x[ra];
		rdz_s1 <= mem_z[ra];
	end

	// Scan pipeline: s1 holds vertex k, the previous register vertex k-1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1 && (idx_s1 != '0);
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		logic signed [W:0]   ez, ex, dl, dzp;
		logic signed [W+1:0] ex2, ez2;
		logic                sdx_neg;
		ez  = (W+1)'(rdz_s1) - (W+1)'(prevz_q);
		ex  = (W+1)'(rdx_s1) - (W+1)'(prevx_q);
		dl  = (W+1)'(px_q) - (W+1)'(prevx_q);
		dzp = (W+1)'(pz_q) - (W+1)'(prevz_q);
		ex2 = ((W+2)'(px_q) <<< 1) - ((W+2)'(prevx_q) + (W+2)'(rdx_s1));
		ez2 = ((W+2)'(pz_q) <<< 1) - ((W+2)'(prevz_q) + (W+2)'(rdz_s1));
		c_cond = ((prevz_q <= pz_q) && (rdz_s1 > pz_q)) ||
			((prevz_q > pz_q) && (rdz_s1 <= pz_q));
		// The edge direction is flipped so that it always points upward in z.
		sdx_neg = ez[W] ? ((ex != '0) && !ex[W]) : ex[W];
		c_ln    = dl[W];
		c_rn    = dzp[W] ^ sdx_neg;
		if (state_q == ST_CROSS) begin
			op1a = {1'b0, W'(dl[W] ? -dl : dl)};
			op1b = {1'b0, W'(ez[W] ? -ez : ez)};
			op2a = {1'b0, W'(dzp[W] ? -dzp : dzp)};
			op2b = {1'b0, W'(ex[W] ? -ex : ex)};
		end else begin
			op1a = (W+1)'(ex2[W+1] ? -ex2 : ex2);
			op1b = op1a;
			op2a = (W+1)'(ez2[W+1] ? -ez2 : ez2);
			op2b = op2a;
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			px_q <= x;
			pz_q <= z;
		end
		idx_s1 <= cnt_q[AW-1:0];
		if (v_s1) begin
			prevx_q <= rdx_s1;
			prevz_q <= rdz_s1;
		end
		op1a_s2  <= op1a;
		op1b_s2  <= op1b;
		op2a_s2  <= op2a;
		op2b_s2  <= op2b;
		cond_s2  <= c_cond;
		ln_s2    <= c_ln;
		rn_s2    <= c_rn;
		j_s2     <= idx_s1 - 1'b1;
		prod1_s3 <= PW'(op1a_s2) * PW'(op1b_s2);
		prod2_s3 <= PW'(op2a_s2) * PW'(op2b_s2);
		cond_s3  <= cond_s2;
		ln_s3    <= ln_s2;
		rn_s3    <= rn_s2;
		j_s3     <= j_s2;
	end

	// Crossing decision: sign-magnitude compare of the two cross products.
	always_comb begin
		n1 = ln_s3 && (prod1_s3 != '0);
		n2 = rn_s3 && (prod2_s3 != '0);
		if (n1 != n2) begin
			lt_cross = n1;
		end else if (n1) begin
			lt_cross = prod1_s3 > prod2_s3;
		end else begin
			lt_cross = prod1_s3 < prod2_s3;
		end
	end

	assign dsum = DW'(prod1_s3) + DW'(prod2_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (query_acc) begin
			parity_q <= 1'b0;
		end else if (v_s3 && (state_q == ST_CROSS) && cond_s3 && lt_cross) begin
			parity_q <= !parity_q;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && (state_q == ST_NEAR) && ((j_s3 == '0) || (dsum < bestd_q))) begin
			best_q  <= j_s3;
			bestd_q <= dsum;
		end
	end

	// Panel vector, halved when either component reaches the sign bit.
	always_comb begin
		dxf  = (W+1)'(rdx_s1) - (W+1)'(x0_q);
		dzf  = (W+1)'(rdz_s1) - (W+1)'(z0_q);
		uxf  = (W+1)'(px_q) - (W+1)'(x0_q);
		uzf  = (W+1)'(pz_q) - (W+1)'(z0_q);
		adxf = W'(dxf[W] ? -dxf : dxf);
		adzf = W'(dzf[W] ? -dzf : dzf);
		big  = adxf[W-1] || adzf[W-1];
	end

	assign qs = {1'b0, div_quot};

	always_ff @(posedge clk) begin
		if ((state_q == ST_FETCH) && (cnt_q == CW'(1))) begin
			x0_q <= rdx_s1;
			z0_q <= rdz_s1;
		end
		if ((state_q == ST_FETCH) && (cnt_q == CW'(2))) begin
			adx_q <= big ? adxf[W-1:1] : adxf[W-2:0];
			adz_q <= big ? adzf[W-1:1] : adzf[W-2:0];
			dxn_q <= dxf[W];
			dzn_q <= dzf[W];
			ux_q  <= uxf;
			uz_q  <= uzf;
		end
		if (state_q == ST_SQ) begin
			dx2_q  <= (2*W-2)'(adx_q) * (2*W-2)'(adx_q);
			dz2_q  <= (2*W-2)'(adz_q) * (2*W-2)'(adz_q);
			dxdz_q <= (2*W-2)'(adx_q) * (2*W-2)'(adz_q);
		end
		if (state_q == ST_PREP) begin
			len_q  <= NW'(dx2_q) + NW'(dz2_q);
			amag_q <= (dx2_q >= dz2_q) ? NW'(dx2_q - dz2_q) : NW'(dz2_q - dx2_q);
			aneg_q <= dz2_q > dx2_q;
			bmag_q <= {dxdz_q, 1'b0};
			bneg_q <= dxn_q ^ dzn_q;
			lenz_q <= (dx2_q == '0) && (dz2_q == '0);
		end
		// A degenerate panel has no direction: the reflection uses a = 1, b = 0.
		if ((state_q == ST_DIV_A) && div_done) begin
			a_q <= lenz_q ? ONE_Q : (aneg_q ? -qs : qs);
		end
		if ((state_q == ST_DIV_B) && div_done) begin
			b_q <= lenz_q ? '0 : (bneg_q ? -qs : qs);
		end
		if (state_q == ST_MUL_A) begin
			m1_q <= MW'(a_q) * MW'(ux_q);
			m2_q <= MW'(b_q) * MW'(uz_q);
		end
		if (state_q == ST_MUL_B) begin
			m3_q <= MW'(b_q) * MW'(ux_q);
			m4_q <= MW'(a_q) * MW'(uz_q);
			sx_q <= (SW'(m1_q) + SW'(m2_q) + RND) >>> FRAC_BITS;
		end
		if (state_q == ST_ROUND) begin
			sz_q <= (SW'(m3_q) - SW'(m4_q) + RND) >>> FRAC_BITS;
		end
	end

	ppr_divider #(
		.NW (NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ((state_q == ST_DIV_B) ? bmag_q : amag_q),
		.den    (len_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Final offset and saturation.
	always_comb begin
		fx = sx_q + SW'(x0_q);
		fz = sz_q + SW'(z0_q);
		if (fx > SAT_HI) begin
			rx = W'(SAT_HI);
		end else if (fx < SAT_LO) begin
			rx = W'(SAT_LO);
		end else begin
			rx = W'(fx);
		end
		if (fz > SAT_HI) begin
			rz = W'(SAT_HI);
		end else if (fz < SAT_LO) begin
			rz = W'(SAT_LO);
		end else begin
			rz = W'(fz);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			x_out_q      <= parity_q ? rx : px_q;
			z_out_q      <= parity_q ? rz : pz_q;
			inside_out_q <= parity_q;
			panel_out_q  <= parity_q ? PANEL_OUT_WIDTH'(best_q) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign x_out         = x_out_q;
	assign z_out         = z_out_q;
	assign was_inside    = inside_out_q;
	assign nearest_panel = panel_out_q;

	// Checks
	a_parity_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CROSS && !query_acc) |=> $stable(parity_q))
		else $error("crossing parity changed outside the crossing scan");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the completion step");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE) && !v_s1 && !v_s3)
		else $error("vertex write while a scan is in flight");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_A || state_q == ST_DIV_B))
		else $error("divider finished outside a division step");

	a_outside_panel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !was_inside) |-> (nearest_panel == '0) && (x_out == $past(x_out) ||
		$rose(out_valid) || !$past(out_valid) || !$past(out_stall)))
		else $error("outside result carries a panel number");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for polygon_point_reflect
// Loads polygons vertex by vertex, sends query points and checks each result
// against an exact software predictor of the crossing test, the nearest
// panel search and the reflection. Directed cases come first, then random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ppr_pkg::*;

	localparam int  NMAX = MAX_PANELS_DEF;
	localparam int  CW   = COORD_WIDTH_DEF;
	localparam longint S = 65536;
	localparam longint CMAX = 64'sd2147483647;
	localparam longint CMIN = -64'sd2147483648;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [CW-1:0]      x;
		logic signed [CW-1:0]      z;
		logic                      in_poly;
		logic [PANEL_OUT_WIDTH-1:0] panel;
	} reflect_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = OP_LOAD;
	logic [IDX_WIDTH-1:0] vertex_index = '0;
	logic signed [CW-1:0] x = '0;
	logic signed [CW-1:0] z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CW-1:0] x_out;
	logic signed [CW-1:0] z_out;
	logic was_inside;
	logic [PANEL_OUT_WIDTH-1:0] nearest_panel;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_WIDTH-1:0] cfg_data = '0;

	polygon_point_reflect uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .vertex_index(vertex_index), .x(x), .z(z),
		.out_valid(out_valid), .out_stall(out_stall),
		.x_out(x_out), .z_out(z_out), .was_inside(was_inside),
		.nearest_panel(nearest_panel),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Predictor state.
	longint poly_x [0:NMAX];
	longint poly_z [0:NMAX];
	int     panels = PANEL_COUNT_MIN;
	reflect_result_t pending_results[$];
	bit     failed = 1'b0;
	int     items_sent = 0;
	int     burst_left = 0;
	int     stall_pct = 0;

	always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

	function automatic longint sat_coord(longint v);
		return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
	endfunction

	// round(num * 2^30 / den) with ties away from zero
	function automatic wide_t coef_q30(longint num, longint den);
		wide_t m, q;
		m = wide_t'(num < 0 ? -num : num);
		q = ((m <<< 31) / wide_t'(den) + 1) >>> 1;
		return num < 0 ? -q : q;
	endfunction

	function automatic reflect_result_t reflect_point(longint px, longint pz);
		reflect_result_t r;
		bit parity;
		int best;
		wide_t best_d, d, lhs, rhs, a, b, ux, uz;
		longint xa, xb, za, zb, ez, ex, sdx, dx, dz, adx, adz, len;
		parity = 0;
		best = 0;
		best_d = 0;
		for (int j = 0; j < panels; j++) begin
			xa = poly_x[j]; xb = poly_x[j+1];
			za = poly_z[j]; zb = poly_z[j+1];
			if ((za <= pz && zb > pz) || (za > pz && zb <= pz)) begin
				ez = zb - za;
				ex = xb - xa;
				sdx = ez > 0 ? ex : -ex;
				lhs = wide_t'(px - xa) * wide_t'(ez < 0 ? -ez : ez);
				rhs = wide_t'(pz - za) * wide_t'(sdx);
				if (lhs < rhs) parity = ~parity;
			end
		end
		r.x = px[CW-1:0];
		r.z = pz[CW-1:0];
		r.in_poly = parity;
		r.panel = '0;
		if (parity) begin
			for (int j = 0; j < panels; j++) begin
				ex = 2 * px - (poly_x[j] + poly_x[j+1]);
				ez = 2 * pz - (poly_z[j] + poly_z[j+1]);
				d = wide_t'(ex) * wide_t'(ex) + wide_t'(ez) * wide_t'(ez);
				if (j == 0 || d < best_d) begin
					best = j;
					best_d = d;
				end
			end
			dx = poly_x[best+1] - poly_x[best];
			dz = poly_z[best+1] - poly_z[best];
			adx = dx < 0 ? -dx : dx;
			adz = dz < 0 ? -dz : dz;
			// Very long panels are halved so that the squared length fits.
			if (adx >= 64'sd2147483648 || adz >= 64'sd2147483648) begin
				adx = adx >>> 1;
				adz = adz >>> 1;
			end
			dx = dx < 0 ? -adx : adx;
			dz = dz < 0 ? -adz : adz;
			len = adx * adx + adz * adz;
			if (len == 0) begin
				a = wide_t'(1) <<< FRAC_BITS;
				b = 0;
			end else begin
				a = coef_q30(dx * dx - dz * dz, len);
				b = coef_q30(2 * dx * dz, len);
			end
			ux = wide_t'(px - poly_x[best]);
			uz = wide_t'(pz - poly_z[best]);
			r.x = CW'(sat_coord(poly_x[best] +
				longint'((a * ux + b * uz + (wide_t'(1) <<< 29)) >>> FRAC_BITS)));
			r.z = CW'(sat_coord(poly_z[best] +
				longint'((b * ux - a * uz + (wide_t'(1) <<< 29)) >>> FRAC_BITS)));
			r.panel = best[PANEL_OUT_WIDTH-1:0];
		end
		return r;
	endfunction

	always @(posedge clk) begin
		reflect_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending: x_out=%0d z_out=%0d", x_out, z_out);
				failed = 1'b1;
			end else begin
				e = pending_results.pop_front();
				if (x_out !== e.x) begin
					$error("x_out expected %0d actual %0d", e.x, x_out);
					failed = 1'b1;
				end
				if (z_out !== e.z) begin
					$error("z_out expected %0d actual %0d", e.z, z_out);
					failed = 1'b1;
				end
				if (was_inside !== e.in_poly) begin
					$error("was_inside expected %0d actual %0d", e.in_poly, was_inside);
					failed = 1'b1;
				end
				if (nearest_panel !== e.panel) begin
					$error("nearest_panel expected %0d actual %0d", e.panel, nearest_panel);
					failed = 1'b1;
				end
			end
		end
	end

	// Sends one request; valid stays high while a burst goes on.
	task automatic send_item(logic op, int idx, longint px, longint pz);
		in_valid <= 1'b1;
		operation <= op;
		vertex_index <= idx[IDX_WIDTH-1:0];
		x <= px[CW-1:0];
		z <= pz[CW-1:0];
		if (op == OP_QUERY)
			pending_results.push_back(reflect_point(px, pz));
		else if (idx <= NMAX) begin
			poly_x[idx] = px;
			poly_z[idx] = pz;
		end
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 4))
				@(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 8);
		end else
			burst_left--;
	endtask

	task automatic load_vertex(int idx, longint px, longint pz);
		send_item(OP_LOAD, idx, px, pz);
	endtask

	task automatic query_point(longint px, longint pz);
		send_item(OP_QUERY, 0, sat_coord(px), sat_coord(pz));
	endtask

	// Stops sending and waits until every expected result has come.
	task automatic drain_results();
		if (in_valid) in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_panel_count(int value);
		cfg_valid <= 1'b1;
		cfg_data <= value[CFG_WIDTH-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		value = value & 9'h1FF;
		panels = value < PANEL_COUNT_MIN ? PANEL_COUNT_MIN : (value > NMAX ? NMAX : value);
	endtask

	function automatic longint rand_coord(int sh);
		return longint'(int'($urandom)) >>> (31 - sh);
	endfunction

	task automatic load_triangle();
		load_vertex(0, 0, 0);
		load_vertex(1, 10 * S, 0);
		load_vertex(2, 0, 10 * S);
		load_vertex(3, 0, 0);
	endtask

	task automatic test_reset_triangle();
		stall_pct = 0;
		load_triangle();
		query_point(2 * S, 2 * S);
		query_point(20 * S, 20 * S);
		query_point(0, 0);
		query_point(5 * S, 0);
		query_point(5 * S, 5 * S);
		query_point(CMAX, CMIN);
		query_point(CMIN, CMAX);
		drain_results();
	endtask

	task automatic test_degenerate_panel();
		stall_pct = 30;
		write_panel_count(5);
		load_vertex(0, 0, 0);
		load_vertex(1, 0, 0);
		load_vertex(2, 10 * S, 0);
		load_vertex(3, 10 * S, 10 * S);
		load_vertex(4, 0, 10 * S);
		load_vertex(5, 0, 0);
		query_point(S / 4, S / 4);
		// The center is equally near all four side midpoints.
		query_point(5 * S, 5 * S);
		query_point(S / 3, 9 * S);
		drain_results();
	endtask

	task automatic test_extreme_coords();
		stall_pct = 50;
		write_panel_count(0);
		load_vertex(0, CMIN, CMIN);
		load_vertex(1, CMAX, CMIN);
		load_vertex(2, 0, CMAX);
		load_vertex(3, CMIN, CMIN);
		query_point(0, 0);
		query_point(CMAX - 5, CMIN + 3);
		query_point(CMIN + 7, CMIN + 1);
		query_point(1000, CMAX - 1000);
		drain_results();
		write_panel_count(2);
		query_point(-S, -S);
		drain_results();
	endtask

	task automatic load_polygon(int sh, bit closed);
		for (int i = 0; i <= panels; i++)
			if (i == panels && closed)
				load_vertex(i, poly_x[0], poly_z[0]);
			else
				load_vertex(i, rand_coord(sh), rand_coord(sh));
	endtask

	task automatic random_query(int sh);
		int k;
		k = $urandom_range(0, panels - 1);
		case ($urandom_range(0, 5))
			0: query_point(rand_coord(31), rand_coord(31));
			1: query_point(poly_x[k] + rand_coord(8), poly_z[k] + rand_coord(8));
			2: query_point((poly_x[k] + poly_x[k+1]) / 2, (poly_z[k] + poly_z[k+1]) / 2);
			default: query_point(rand_coord(sh), rand_coord(sh));
		endcase
	endtask

	task automatic test_max_panels();
		stall_pct = 20;
		write_panel_count(511);
		load_polygon(24, 1);
		load_vertex(257, 1, 1);
		load_vertex(511, CMAX, CMIN);
		for (int i = 0; i < 12; i++) random_query(24);
		drain_results();
		write_panel_count(300);
		for (int i = 0; i < 4; i++) random_query(31);
		drain_results();
		write_panel_count(256);
		load_vertex(256, 0, 0);
		for (int i = 0; i < 4; i++) random_query(24);
		drain_results();
	endtask

	task automatic test_random_polygons();
		int sh, nq;
		while (items_sent < 1050) begin
			stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 80);
			write_panel_count($urandom_range(0, 7) == 0 ? $urandom_range(0, 511)
				: $urandom_range(3, 12));
			if (panels > 40 && $urandom_range(0, 3) != 0)
				write_panel_count($urandom_range(3, 40));
			sh = $urandom_range(0, 4) == 0 ? 31 : $urandom_range(10, 28);
			load_polygon(sh, $urandom_range(0, 5) != 0);
			nq = $urandom_range(10, 40);
			for (int i = 0; i < nq; i++) begin
				case ($urandom_range(0, 9))
					0: load_vertex($urandom_range(257, 511), rand_coord(31), rand_coord(31));
					1: load_vertex($urandom_range(0, panels), rand_coord(sh), rand_coord(sh));
					default: random_query(sh);
				endcase
			end
			drain_results();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_triangle();
		test_degenerate_panel();
		test_extreme_coords();
		test_max_panels();
		test_random_polygons();
		drain_results();
		repeat (50) @(posedge clk);
		if (!failed && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
